FILE: hw/rtl/icd_pkg.sv
// Package for the interlace comb detector: widths, register indexes,
// configuration and pipeline stage types, a shared helper function.
// No dependencies.
package icd_pkg;

  // Pixel width (8..16).
  localparam int unsigned PIXEL_BITS = 8;
  localparam int unsigned NUM_PIX = 11;

  // Stream widths.
  localparam int unsigned IN_DATA_W = ((NUM_PIX * PIXEL_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = 8;

  // Internal widths.
  localparam int unsigned DIF_W = PIXEL_BITS + 1;       // signed pixel difference
  localparam int unsigned CMP_W = PIXEL_BITS + 2;       // signed compare width
  localparam int unsigned SUMA_W = PIXEL_BITS + 3;      // u2 + d2 + 4c
  localparam int unsigned SUMB_W = PIXEL_BITS + 1;      // u1 + d1
  localparam int unsigned SCORE_W = PIXEL_BITS + 4;     // signed bob+blur score
  localparam int unsigned MAG_W = PIXEL_BITS + 3;       // score magnitude
  localparam int unsigned PROD_W = 2 * PIXEL_BITS + 2;  // signed product

  // Configuration port.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_METRIC_SELECT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPATIAL_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPATIAL_LIMIT_SQ = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPATIAL_LIMIT_SIX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_CHECK = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_LIMIT = 3'd7;

  typedef enum logic [1:0] {
    METRIC_MINMAX  = 2'd0,
    METRIC_PRODUCT = 2'd1,
    METRIC_SCORE   = 2'd2
  } metric_e;

  typedef struct packed {
    logic [1:0]  metric_select;
    logic [7:0]  motion_limit;
    logic [7:0]  spatial_limit;
    logic [15:0] spatial_limit_sq;
    logic [10:0] spatial_limit_six;
    logic        force_check;
    logic [7:0]  near_limit;
    logic [7:0]  far_limit;
  } cfg_t;

  typedef logic [PIXEL_BITS-1:0] pix_t;

  typedef struct packed {
    logic row_in_range;
    pix_t cur_up_two;
    pix_t cur_up_one;
    pix_t cur_center;
    pix_t cur_down_one;
    pix_t cur_down_two;
    pix_t prev_up_one;
    pix_t prev_center;
    pix_t prev_down_one;
    pix_t next_up_one;
    pix_t next_center;
    pix_t next_down_one;
  } pix_in_t;

  // Stage 1 result: differences and partial sums.
  typedef struct packed {
    logic                     row_in_range;
    logic signed [DIF_W-1:0]  dif_up;      // u1 - c
    logic signed [DIF_W-1:0]  dif_dn;      // d1 - c
    pix_t                     ad_fwd_c;    // |pc - c|
    pix_t                     ad_fwd_u;    // |u1 - nu|
    pix_t                     ad_fwd_d;    // |d1 - nd|
    pix_t                     ad_bwd_c;    // |nc - c|
    pix_t                     ad_bwd_u;    // |pu - u1|
    pix_t                     ad_bwd_d;    // |pd - d1|
    pix_t                     ad_near;     // |c - d2|
    pix_t                     ad_far;      // |c - d1|
    logic [SUMA_W-1:0]        sum_a;
    logic [SUMB_W-1:0]        sum_b;
  } s1_t;

  // Stage 2 result: gate/motion decision and raw metrics.
  typedef struct packed {
    logic                       armed;
    logic                       mark_minmax;
    logic signed [PROD_W-1:0]   prod;
    logic signed [SCORE_W-1:0]  score;
  } s2_t;

  function automatic pix_t abs_diff(input pix_t a, input pix_t b);
    return (a > b) ? pix_t'(a - b) : pix_t'(b - a);
  endfunction

endpackage

FILE: hw/rtl/interlace_comb_detector.sv
// Interlace comb detector, top level: config registers and a 3-stage pipeline.
// Each input is registered in stages 1, 2, 3; 1 pixel/clock unless the output stalls.
// Each stage holds one item; a stage loads when it is empty or its result moves on,
// so the input keeps taking transfers while a result waits as long as a bubble exists.
// Reset (rst_ni, async, active low) empties the pipeline and loads register defaults.
// Depends on icd_pkg, icd_delta, icd_eval, icd_decide.
module interlace_comb_detector (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input pixel stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata, low bit up: cur_up_two, cur_up_one, cur_center, cur_down_one,
  // cur_down_two, prev_up_one, prev_center, prev_down_one, next_up_one,
  // next_center, next_down_one
  input  logic [icd_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  input  logic                              s_axis_tuser_i,   // row_in_range
  // Result stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [icd_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,   // combed, zero padded
  // Register write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [icd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [icd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import icd_pkg::*;

  cfg_t    cfg_q;
  pix_in_t pix;

  logic s1_valid, s1_ready, s2_valid, s2_ready;
  s1_t  s1_data;
  s2_t  s2_data;
  logic combed;

  // Registers are always writable; writes must only happen while idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.metric_select     <= METRIC_SCORE;
      cfg_q.motion_limit      <= 8'd3;
      cfg_q.spatial_limit     <= 8'd3;
      cfg_q.spatial_limit_sq  <= 16'd9;
      cfg_q.spatial_limit_six <= 11'd18;
      cfg_q.force_check       <= 1'b0;
      cfg_q.near_limit        <= 8'd10;
      cfg_q.far_limit         <= 8'd15;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_METRIC_SELECT:     cfg_q.metric_select     <= cfg_data_i[1:0];
        REG_MOTION_LIMIT:      cfg_q.motion_limit      <= cfg_data_i[7:0];
        REG_SPATIAL_LIMIT:     cfg_q.spatial_limit     <= cfg_data_i[7:0];
        REG_SPATIAL_LIMIT_SQ:  cfg_q.spatial_limit_sq  <= cfg_data_i[15:0];
        REG_SPATIAL_LIMIT_SIX: cfg_q.spatial_limit_six <= cfg_data_i[10:0];
        REG_FORCE_CHECK:       cfg_q.force_check       <= cfg_data_i[0];
        REG_NEAR_LIMIT:        cfg_q.near_limit        <= cfg_data_i[7:0];
        REG_FAR_LIMIT:         cfg_q.far_limit         <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Unpack tdata, first field in the lowest bits.
  always_comb begin
    pix.row_in_range  = s_axis_tuser_i;
    pix.cur_up_two    = s_axis_tdata_i[0*PIXEL_BITS +: PIXEL_BITS];
    pix.cur_up_one    = s_axis_tdata_i[1*PIXEL_BITS +: PIXEL_BITS];
    pix.cur_center    = s_axis_tdata_i[2*PIXEL_BITS +: PIXEL_BITS];
    pix.cur_down_one  = s_axis_tdata_i[3*PIXEL_BITS +: PIXEL_BITS];
    pix.cur_down_two  = s_axis_tdata_i[4*PIXEL_BITS +: PIXEL_BITS];
    pix.prev_up_one   = s_axis_tdata_i[5*PIXEL_BITS +: PIXEL_BITS];
    pix.prev_center   = s_axis_tdata_i[6*PIXEL_BITS +: PIXEL_BITS];
    pix.prev_down_one = s_axis_tdata_i[7*PIXEL_BITS +: PIXEL_BITS];
    pix.next_up_one   = s_axis_tdata_i[8*PIXEL_BITS +: PIXEL_BITS];
    pix.next_center   = s_axis_tdata_i[9*PIXEL_BITS +: PIXEL_BITS];
    pix.next_down_one = s_axis_tdata_i[10*PIXEL_BITS +: PIXEL_BITS];
  end

  // Stage 1: differences, absolute differences, partial sums
  icd_delta u_delta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .pix_i   (pix),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  // Stage 2: gate, motion test, product multiply, score add
  icd_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  // Stage 3: thresholds, metric select, output register
  icd_decide u_decide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .valid_i  (s2_valid),
    .ready_o  (s2_ready),
    .data_i   (s2_data),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .combed_o (combed)
  );

  assign m_axis_tdata_o = OUT_DATA_W'(combed);

endmodule

FILE: hw/rtl/icd_delta.sv
// Stage 1 of the comb detector: pixel differences and partial sums.
// Depends on icd_pkg.
module icd_delta (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  icd_pkg::pix_in_t pix_i,
  output logic            valid_o,
  input  logic            ready_i,
  output icd_pkg::s1_t    data_o
);
  import icd_pkg::*;

  logic valid_q;
  s1_t  data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.row_in_range = pix_i.row_in_range;
    data_d.dif_up = $signed({1'b0, pix_i.cur_up_one}) - $signed({1'b0, pix_i.cur_center});
    data_d.dif_dn = $signed({1'b0, pix_i.cur_down_one}) - $signed({1'b0, pix_i.cur_center});
    data_d.ad_fwd_c = abs_diff(pix_i.prev_center, pix_i.cur_center);
    data_d.ad_fwd_u = abs_diff(pix_i.cur_up_one, pix_i.next_up_one);
    data_d.ad_fwd_d = abs_diff(pix_i.cur_down_one, pix_i.next_down_one);
    data_d.ad_bwd_c = abs_diff(pix_i.next_center, pix_i.cur_center);
    data_d.ad_bwd_u = abs_diff(pix_i.prev_up_one, pix_i.cur_up_one);
    data_d.ad_bwd_d = abs_diff(pix_i.prev_down_one, pix_i.cur_down_one);
    data_d.ad_near = abs_diff(pix_i.cur_center, pix_i.cur_down_two);
    data_d.ad_far = abs_diff(pix_i.cur_center, pix_i.cur_down_one);
    data_d.sum_a = SUMA_W'(pix_i.cur_up_two) + SUMA_W'(pix_i.cur_down_two)
                 + {1'b0, pix_i.cur_center, 2'b00};
    data_d.sum_b = SUMB_W'(pix_i.cur_up_one) + SUMB_W'(pix_i.cur_down_one);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o = data_q;

endmodule

FILE: hw/rtl/icd_eval.sv
// Stage 2 of the comb detector: spatial gate, motion test, product and score.
// Depends on icd_pkg.
module icd_eval (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  icd_pkg::cfg_t cfg_i,
  input  logic          valid_i,
  output logic          ready_o,
  input  icd_pkg::s1_t  data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output icd_pkg::s2_t  data_o
);
  import icd_pkg::*;

  logic valid_q;
  s2_t  data_d, data_q;

  logic signed [CMP_W-1:0] at_pos, at_neg, up_ext, dn_ext;
  pix_t                    mt, near_ext, far_ext;
  logic                    gate, fwd, bwd, motion;
  logic [SUMA_W-1:0]       sum_b3;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    at_pos = $signed(CMP_W'(cfg_i.spatial_limit));
    at_neg = -at_pos;
    up_ext = CMP_W'(data_i.dif_up);
    dn_ext = CMP_W'(data_i.dif_dn);
    // c - u1 > at is u1 - c < -at, and likewise below
    gate = (up_ext < at_neg && dn_ext < at_neg) || (up_ext > at_pos && dn_ext > at_pos);

    mt = pix_t'(cfg_i.motion_limit);
    fwd = data_i.ad_fwd_c > mt && data_i.ad_fwd_u > mt && data_i.ad_fwd_d > mt;
    bwd = data_i.ad_bwd_c > mt && data_i.ad_bwd_u > mt && data_i.ad_bwd_d > mt;
    motion = (cfg_i.motion_limit == 8'd0) || fwd || bwd;

    near_ext = pix_t'(cfg_i.near_limit);
    far_ext = pix_t'(cfg_i.far_limit);

    sum_b3 = {1'b0, data_i.sum_b, 1'b0} + SUMA_W'(data_i.sum_b);

    data_d.armed = data_i.row_in_range && gate && (motion || cfg_i.force_check);
    data_d.mark_minmax = data_i.ad_near < near_ext && data_i.ad_far > far_ext;
    data_d.prod = data_i.dif_up * data_i.dif_dn;
    data_d.score = $signed({1'b0, data_i.sum_a}) - $signed({1'b0, sum_b3});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o = data_q;

endmodule

FILE: hw/rtl/icd_decide.sv
// Stage 3 of the comb detector: metric thresholds, selection, output register.
// Depends on icd_pkg.
module icd_decide (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  icd_pkg::cfg_t cfg_i,
  input  logic          valid_i,
  output logic          ready_o,
  input  icd_pkg::s2_t  data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic          combed_o
);
  import icd_pkg::*;

  logic valid_q;
  logic combed_d, combed_q;

  logic signed [SCORE_W-1:0] score_abs;
  logic [MAG_W-1:0]          mag;
  logic                      prod_hit, score_hit;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    score_abs = (data_i.score < 0) ? -data_i.score : data_i.score;
    mag = score_abs[MAG_W-1:0];
    prod_hit = data_i.prod > $signed(PROD_W'(cfg_i.spatial_limit_sq));
    score_hit = mag > MAG_W'(cfg_i.spatial_limit_six);
    case (cfg_i.metric_select)
      METRIC_MINMAX:  combed_d = data_i.armed && data_i.mark_minmax;
      METRIC_PRODUCT: combed_d = data_i.armed && prod_hit;
      METRIC_SCORE:   combed_d = data_i.armed && score_hit;
      default:        combed_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      combed_q <= combed_d;
    end
  end

  assign valid_o = valid_q;
  assign combed_o = combed_q;

endmodule

FILE: tb/interlace_comb_detector_tb.sv
// Self-checking testbench for interlace_comb_detector: directed stimulus table, then
// random phases with random register settings, checked by a local predictor or typed results.
// Depends on icd_pkg and the interlace_comb_detector RTL.
module interlace_comb_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import icd_pkg::*;

  // metric code with no metric behind it: marks nothing
  localparam logic [1:0] METRIC_UNUSED = 2'd3;

  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 112;
  localparam int HOLD_CYCLES = 300;   // long result-side stall
  localparam int QUIET_LIMIT = 2000;  // cycles without any transfer
  localparam int MAX_REPORTS = 10;

  // Register presets for the directed part. Entry 0 holds the reset values and is
  // never written; the others are written as a whole.
  localparam cfg_t SETTING_PRESETS [7] = '{
    '{METRIC_SCORE,   8'd3,   8'd3,   16'd9,     11'd18,   1'b0, 8'd10,  8'd15},
    '{METRIC_MINMAX,  8'd3,   8'd3,   16'd9,     11'd18,   1'b0, 8'd10,  8'd15},
    '{METRIC_PRODUCT, 8'd3,   8'd3,   16'd65024, 11'd18,   1'b0, 8'd10,  8'd15},
    '{METRIC_UNUSED,  8'd0,   8'd0,   16'd0,     11'd0,    1'b1, 8'd255, 8'd0},
    '{METRIC_SCORE,   8'd0,   8'd0,   16'd0,     11'd0,    1'b0, 8'd0,   8'd0},
    '{METRIC_MINMAX,  8'd255, 8'd255, 16'd65025, 11'd1530, 1'b1, 8'd255, 8'd255},
    '{METRIC_PRODUCT, 8'd0,   8'd0,   16'd65025, 11'd1530, 1'b0, 8'd0,   8'd255}
  };

  // One directed row: preset to run under, the pixel item, and an optional
  // hand-typed result (typed_ok = 1) that replaces the prediction.
  typedef struct packed {
    logic [2:0] preset;
    pix_in_t    item;
    logic       typed_ok;
    logic       typed_combed;
  } directed_row_t;

  // Item field order: row_in_range, cur_up_two, cur_up_one, cur_center, cur_down_one,
  // cur_down_two, prev_up_one, prev_center, prev_down_one, next_up_one, next_center,
  // next_down_one.
  localparam directed_row_t DIRECTED_ROWS [22] = '{
    // reset settings: bob+blur score, motion and spatial limit 3
    // row outside the detection range
    '{3'd0, '{1'b0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0,
              8'd255, 8'd255, 8'd255}, 1'b1, 1'b0},
    // strongest bright comb, forward motion
    '{3'd0, '{1'b1, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0,
              8'd255, 8'd255, 8'd255}, 1'b0, 1'b0},
    // flat black and flat white never pass the gate
    '{3'd0, '{1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
              8'd0, 8'd0, 8'd0}, 1'b1, 1'b0},
    '{3'd0, '{1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
              8'd255, 8'd255, 8'd255}, 1'b1, 1'b0},
    // dark comb, backward motion only
    '{3'd0, '{1'b1, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0,
              8'd255, 8'd255, 8'd255}, 1'b0, 1'b0},
    // comb without motion, no forced check
    '{3'd0, '{1'b1, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0,
              8'd0, 8'd255, 8'd0}, 1'b0, 1'b0},
    // vertical differences of opposite sign
    '{3'd0, '{1'b1, 8'd128, 8'd0, 8'd128, 8'd255, 8'd128, 8'd0, 8'd0, 8'd0,
              8'd255, 8'd255, 8'd255}, 1'b0, 1'b0},
    // differences equal to the spatial limit
    '{3'd0, '{1'b1, 8'd10, 8'd7, 8'd10, 8'd7, 8'd10, 8'd0, 8'd200, 8'd0,
              8'd200, 8'd0, 8'd200}, 1'b0, 1'b0},
    // min/max difference: pass, near limit touched, far limit touched
    '{3'd1, '{1'b1, 8'd0, 8'd100, 8'd200, 8'd100, 8'd195, 8'd0, 8'd0, 8'd0,
              8'd255, 8'd200, 8'd255}, 1'b0, 1'b0},
    '{3'd1, '{1'b1, 8'd0, 8'd100, 8'd200, 8'd100, 8'd190, 8'd0, 8'd0, 8'd0,
              8'd255, 8'd200, 8'd255}, 1'b0, 1'b0},
    '{3'd1, '{1'b1, 8'd30, 8'd10, 8'd30, 8'd15, 8'd30, 8'd0, 8'd255, 8'd0,
              8'd255, 8'd30, 8'd255}, 1'b0, 1'b0},
    // product: largest product just above its limit, then just below
    '{3'd2, '{1'b1, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0,
              8'd0, 8'd0, 8'd0}, 1'b0, 1'b0},
    '{3'd2, '{1'b1, 8'd255, 8'd1, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0,
              8'd255, 8'd255, 8'd255}, 1'b0, 1'b0},
    // unused metric code, forced check: never marked
    '{3'd3, '{1'b1, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0,
              8'd255, 8'd255, 8'd255}, 1'b1, 1'b0},
    '{3'd3, '{1'b1, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0,
              8'd0, 8'd0, 8'd0}, 1'b1, 1'b0},
    // all limits zero: motion test off, score exactly zero, then one, then a flat row
    '{3'd4, '{1'b1, 8'd0, 8'd2, 8'd3, 8'd2, 8'd0, 8'd2, 8'd3, 8'd2,
              8'd2, 8'd3, 8'd2}, 1'b0, 1'b0},
    '{3'd4, '{1'b1, 8'd1, 8'd2, 8'd3, 8'd2, 8'd0, 8'd2, 8'd3, 8'd2,
              8'd2, 8'd3, 8'd2}, 1'b0, 1'b0},
    '{3'd4, '{1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255,
              8'd255, 8'd255, 8'd255}, 1'b0, 1'b0},
    // all limits at maximum: the gate can never pass
    '{3'd5, '{1'b1, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255,
              8'd255, 8'd0, 8'd255}, 1'b1, 1'b0},
    '{3'd5, '{1'b1, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0,
              8'd0, 8'd255, 8'd0}, 1'b1, 1'b0},
    // largest product equals the largest product limit
    '{3'd6, '{1'b1, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0,
              8'd0, 8'd0, 8'd0}, 1'b1, 1'b0},
    '{3'd6, '{1'b1, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255,
              8'd255, 8'd255, 8'd255}, 1'b1, 1'b0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                  s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Scoreboard state
  cfg_t settings_model = SETTING_PRESETS[0];  // registers as the block should hold them
  logic combed_q [$];                         // expected combed bits, oldest first
  int   mismatches = 0;
  int   quiet_cycles = 0;

  // Hint for the pixel in flight on the input: hand-typed result, if any
  logic hint_ok = 1'b0;
  logic hint_combed = 1'b0;

  // Idle control for the sender and the receiver
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit hold_req = 1'b0;

  interlace_comb_detector dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int pix_dist(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic predict_combed(input pix_in_t px, input cfg_t cf);
    int   u2, u1, c, d1, d2, pu, pc, pd, nu, nc, nd;
    int   up_gap, dn_gap, sp_lim, mo_lim, score;
    logic fwd, bwd, moving;
    u2 = int'(px.cur_up_two);   u1 = int'(px.cur_up_one);
    c  = int'(px.cur_center);
    d1 = int'(px.cur_down_one); d2 = int'(px.cur_down_two);
    pu = int'(px.prev_up_one);  pc = int'(px.prev_center);  pd = int'(px.prev_down_one);
    nu = int'(px.next_up_one);  nc = int'(px.next_center);  nd = int'(px.next_down_one);
    sp_lim = int'(cf.spatial_limit);
    mo_lim = int'(cf.motion_limit);
    up_gap = c - u1;
    dn_gap = c - d1;

    if (!px.row_in_range) return 1'b0;
    // spatial gate: both vertical steps beyond the limit, same direction
    if (!((up_gap > sp_lim && dn_gap > sp_lim) || (up_gap < -sp_lim && dn_gap < -sp_lim)))
      return 1'b0;

    // motion against either neighbor frame; a zero limit turns the test off
    if (mo_lim == 0) begin
      moving = 1'b1;
    end else begin
      fwd = pix_dist(pc, c) > mo_lim && pix_dist(u1, nu) > mo_lim &&
            pix_dist(d1, nd) > mo_lim;
      bwd = pix_dist(nc, c) > mo_lim && pix_dist(pu, u1) > mo_lim &&
            pix_dist(pd, d1) > mo_lim;
      moving = fwd || bwd;
    end
    if (!moving && !cf.force_check) return 1'b0;

    case (cf.metric_select)
      METRIC_MINMAX:
        return pix_dist(c, d2) < int'(cf.near_limit) && pix_dist(c, d1) > int'(cf.far_limit);
      METRIC_PRODUCT:
        return (u1 - c) * (d1 - c) > int'(cf.spatial_limit_sq);
      METRIC_SCORE: begin
        score = u2 + 4 * c + d2 - 3 * (u1 + d1);
        if (score < 0) score = -score;
        return score > int'(cf.spatial_limit_six);
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Random stimulus
  // ---------------------------------------------------------------------------
  function automatic pix_t pix_near(input int v);
    int t;
    t = v + int'($urandom_range(0, 8)) - 4;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return pix_t'(t);
  endfunction

  // value at least one step away from v, anywhere up to the far end of the range
  function automatic pix_t pix_far(input int v);
    return (v < 128) ? pix_t'($urandom_range(v + 1, 255)) : pix_t'($urandom_range(0, v - 1));
  endfunction

  // Mostly comb-shaped neighborhoods with chosen motion, some pure noise.
  function automatic pix_in_t random_pixel();
    logic [95:0] noise;
    pix_in_t     px;
    int          c, u1, d1;
    noise = {$urandom(), $urandom(), $urandom()};
    px = noise[$bits(pix_in_t)-1:0];
    if ($urandom_range(0, 9) < 7) begin
      c = $urandom_range(0, 255);
      if ($urandom_range(0, 1) == 1) begin
        u1 = $urandom_range(0, c);
        d1 = $urandom_range(0, c);
      end else begin
        u1 = $urandom_range(c, 255);
        d1 = $urandom_range(c, 255);
      end
      px.row_in_range = ($urandom_range(0, 15) != 0);
      px.cur_center   = pix_t'(c);
      px.cur_up_one   = pix_t'(u1);
      px.cur_down_one = pix_t'(d1);
      if ($urandom_range(0, 1) == 1) begin
        px.cur_up_two   = pix_near(c);
        px.cur_down_two = pix_near(c);
      end
      case ($urandom_range(0, 3))
        0: begin  // moved against the previous frame
          px.prev_center = pix_far(c);  px.next_up_one = pix_far(u1);
          px.next_down_one = pix_far(d1);
          px.next_center = pix_near(c); px.prev_up_one = pix_near(u1);
          px.prev_down_one = pix_near(d1);
        end
        1: begin  // moved against the next frame
          px.next_center = pix_far(c);  px.prev_up_one = pix_far(u1);
          px.prev_down_one = pix_far(d1);
          px.prev_center = pix_near(c); px.next_up_one = pix_near(u1);
          px.next_down_one = pix_near(d1);
        end
        2: begin  // still picture
          px.prev_center = pix_near(c);  px.prev_up_one = pix_near(u1);
          px.prev_down_one = pix_near(d1);
          px.next_center = pix_near(c);  px.next_up_one = pix_near(u1);
          px.next_down_one = pix_near(d1);
        end
        default: ;  // neighbor frames left as noise
      endcase
    end
    return px;
  endfunction

  function automatic cfg_t random_settings();
    cfg_t cf;
    int   pick;
    cf.metric_select = ($urandom_range(0, 11) == 0) ? METRIC_UNUSED
                                                    : 2'($urandom_range(0, 2));
    pick = $urandom_range(0, 9);
    cf.motion_limit = (pick < 2) ? 8'd0 : (pick == 2) ? 8'd255 : 8'($urandom_range(1, 40));
    pick = $urandom_range(0, 9);
    cf.spatial_limit = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(1, 40));
    cf.spatial_limit_sq = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65025))
                        : 16'(int'(cf.spatial_limit) * int'(cf.spatial_limit));
    cf.spatial_limit_six = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 1530))
                         : 11'(6 * int'(cf.spatial_limit));
    cf.force_check = 1'($urandom_range(0, 1));
    cf.near_limit = 8'($urandom_range(0, 255));
    cf.far_limit = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 60));
    return cf;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers: every task starts and ends on a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_pixel(input pix_in_t px, input logic typed_ok, input logic typed_combed);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= px.row_in_range;
    s_axis_tdata_i  <= IN_DATA_W'({px.next_down_one, px.next_center, px.next_up_one,
                                   px.prev_down_one, px.prev_center, px.prev_up_one,
                                   px.cur_down_two, px.cur_down_one, px.cur_center,
                                   px.cur_up_one, px.cur_up_two});
    hint_ok     = typed_ok;
    hint_combed = typed_combed;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic load_settings(input cfg_t cf);
    write_reg(REG_METRIC_SELECT,     CFG_DATA_W'(cf.metric_select));
    write_reg(REG_MOTION_LIMIT,      CFG_DATA_W'(cf.motion_limit));
    write_reg(REG_SPATIAL_LIMIT,     CFG_DATA_W'(cf.spatial_limit));
    write_reg(REG_SPATIAL_LIMIT_SQ,  CFG_DATA_W'(cf.spatial_limit_sq));
    write_reg(REG_SPATIAL_LIMIT_SIX, CFG_DATA_W'(cf.spatial_limit_six));
    write_reg(REG_FORCE_CHECK,       CFG_DATA_W'(cf.force_check));
    write_reg(REG_NEAR_LIMIT,        CFG_DATA_W'(cf.near_limit));
    write_reg(REG_FAR_LIMIT,         CFG_DATA_W'(cf.far_limit));
    cfg_valid_i <= 1'b0;
  endtask

  // Stop offering pixels and wait until every expected result is back.
  task automatic drain_pipeline();
    s_axis_tvalid_i <= 1'b0;
    while (combed_q.size() != 0) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold that backs the pipeline up
  // ---------------------------------------------------------------------------
  initial begin
    m_axis_tready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: register mirror, result check, prediction at input transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pix_in_t px;
    logic    want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_METRIC_SELECT:     settings_model.metric_select     = cfg_data_i[1:0];
          REG_MOTION_LIMIT:      settings_model.motion_limit      = cfg_data_i[7:0];
          REG_SPATIAL_LIMIT:     settings_model.spatial_limit     = cfg_data_i[7:0];
          REG_SPATIAL_LIMIT_SQ:  settings_model.spatial_limit_sq  = cfg_data_i[15:0];
          REG_SPATIAL_LIMIT_SIX: settings_model.spatial_limit_six = cfg_data_i[10:0];
          REG_FORCE_CHECK:       settings_model.force_check       = cfg_data_i[0];
          REG_NEAR_LIMIT:        settings_model.near_limit        = cfg_data_i[7:0];
          REG_FAR_LIMIT:         settings_model.far_limit         = cfg_data_i[7:0];
          default: ;
        endcase
      end

      // result side first: it always belongs to an older pixel
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (combed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with nothing expected, tdata %h", $realtime, m_axis_tdata_o);
        end else begin
          want = combed_q.pop_front();
          // combed in bit 0, padding above must be zero
          if (m_axis_tdata_o !== OUT_DATA_W'(want)) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: combed mismatch, expected %0d, got tdata %h",
                       $realtime, want, m_axis_tdata_o);
          end
        end
      end

      if (s_axis_tvalid_i && s_axis_tready_o) begin
        px.row_in_range  = s_axis_tuser_i;
        px.cur_up_two    = s_axis_tdata_i[0*PIXEL_BITS +: PIXEL_BITS];
        px.cur_up_one    = s_axis_tdata_i[1*PIXEL_BITS +: PIXEL_BITS];
        px.cur_center    = s_axis_tdata_i[2*PIXEL_BITS +: PIXEL_BITS];
        px.cur_down_one  = s_axis_tdata_i[3*PIXEL_BITS +: PIXEL_BITS];
        px.cur_down_two  = s_axis_tdata_i[4*PIXEL_BITS +: PIXEL_BITS];
        px.prev_up_one   = s_axis_tdata_i[5*PIXEL_BITS +: PIXEL_BITS];
        px.prev_center   = s_axis_tdata_i[6*PIXEL_BITS +: PIXEL_BITS];
        px.prev_down_one = s_axis_tdata_i[7*PIXEL_BITS +: PIXEL_BITS];
        px.next_up_one   = s_axis_tdata_i[8*PIXEL_BITS +: PIXEL_BITS];
        px.next_center   = s_axis_tdata_i[9*PIXEL_BITS +: PIXEL_BITS];
        px.next_down_one = s_axis_tdata_i[10*PIXEL_BITS +: PIXEL_BITS];
        combed_q.push_back(hint_ok ? hint_combed : predict_combed(px, settings_model));
      end

      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: too long without any transfer means the block is stuck.
  initial begin
    wait (rst_ni === 1'b1);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int active_preset;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table; first rows run on the reset values of the registers.
    active_preset = 0;
    foreach (DIRECTED_ROWS[i]) begin
      if (int'(DIRECTED_ROWS[i].preset) != active_preset) begin
        drain_pipeline();
        active_preset = int'(DIRECTED_ROWS[i].preset);
        load_settings(SETTING_PRESETS[active_preset]);
      end
      send_pixel(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed_ok,
                 DIRECTED_ROWS[i].typed_combed);
    end
    drain_pipeline();

    // Random phases, each under fresh register settings loaded while idle.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      load_settings(random_settings());
      // last phase runs flat out on both sides
      if (ph == NUM_PHASES - 1) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      // one phase starts with the receiver held off while pixels keep coming
      if (ph == 2) hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_pixel(random_pixel(), 1'b0, 1'b0);
      drain_pipeline();
    end

    // wait past the pipeline depth to catch stray results
    repeat (12) @(posedge clk_i);
    if (mismatches == 0 && combed_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
